/* rtl/ipsp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsp_pkg
// Shared types and constants of the IPS patch stream parser: result kinds,
// status codes, parse phases, header and end-marker text.
// ----------------------------------------------------------------------------
package ipsp_pkg;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // parse status
    localparam logic [1:0] ST_BUSY       = 2'd0;
    localparam logic [1:0] ST_BAD_HDR    = 2'd1;
    localparam logic [1:0] ST_EOF_MARK   = 2'd2;
    localparam logic [1:0] ST_STREAM_END = 2'd3;

    // parse phases
    localparam logic [2:0] PH_HEAD   = 3'd0;
    localparam logic [2:0] PH_OFFSET = 3'd1;
    localparam logic [2:0] PH_SIZE   = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_RCOUNT = 3'd4;
    localparam logic [2:0] PH_RVALUE = 3'd5;

    // three offset bytes "EOF" end the patch
    localparam logic [23:0] EOF_MARK = 24'h454F46;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] address;
        logic [7:0]  value;
        logic [15:0] run_length;
        logic [24:0] image_size;
        logic [1:0]  status;
        logic [15:0] record_count;
    } t_result;

    // expected header text "PATCH", one character per position
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h41;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h43;
            3'd4:    c = 8'h48;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/ipsp_parse_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsp_parse_core
// Parse state machine: header check, record fields, literal data and fill
// records. Advances one byte per accepted transfer and forms the result.
// ----------------------------------------------------------------------------
module ipsp_parse_core
    import ipsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [23:0] i_orig_size,
    output logic        o_res_valid,
    output t_result     o_res
);

    logic [2:0]  r_phase,   n_phase;
    logic [2:0]  r_field,   n_field;
    logic [23:0] r_marker,  n_marker;
    logic [23:0] r_offset,  n_offset;
    logic [15:0] r_bytes,   n_bytes;
    logic [23:0] r_waddr,   n_waddr;
    logic [24:0] r_size,    n_size;
    logic [15:0] r_records, n_records;
    logic        r_finished, n_finished;

    logic [24:0] grow_end;
    logic [15:0] rec_inc;

    // shared end-of-record adder and saturating record count
    // the length is the size just completed, or the held fill count
    assign grow_end = {1'b0, r_offset}
                    + {9'd0, (r_phase == PH_SIZE) ? {r_bytes[7:0], i_byte} : r_bytes};
    assign rec_inc  = (r_records != 16'hFFFF) ? r_records + 16'd1 : r_records;

    // next state and result
    always_comb begin
        n_phase    = r_phase;
        n_field    = r_field;
        n_marker   = r_marker;
        n_offset   = r_offset;
        n_bytes    = r_bytes;
        n_waddr    = r_waddr;
        n_size     = r_size;
        n_records  = r_records;
        n_finished = r_finished;

        o_res_valid        = 1'b0;
        o_res.kind         = KIND_DONE;
        o_res.address      = 24'd0;
        o_res.value        = 8'd0;
        o_res.run_length   = 16'd1;
        o_res.status       = ST_BUSY;

        if (!r_finished) begin
            case (r_phase)
                PH_HEAD: begin
                    if (r_field > 3'd4 || i_byte != hdr_char(r_field)) begin
                        n_finished   = 1'b1;
                        o_res_valid  = 1'b1;
                        o_res.status = ST_BAD_HDR;
                    end else if (r_field == 3'd4) begin
                        n_field  = 3'd0;
                        n_marker = 24'd0;
                        n_size   = {1'b0, i_orig_size};
                        n_phase  = PH_OFFSET;
                    end else begin
                        n_field = r_field + 3'd1;
                    end
                end
                PH_OFFSET: begin
                    n_marker = {r_marker[15:0], i_byte};
                    if (r_field == 3'd2) begin
                        n_field = 3'd0;
                        if (n_marker == EOF_MARK) begin
                            n_finished   = 1'b1;
                            o_res_valid  = 1'b1;
                            o_res.status = ST_EOF_MARK;
                        end else begin
                            n_offset = n_marker;
                            n_bytes  = 16'd0;
                            n_phase  = PH_SIZE;
                        end
                    end else begin
                        n_field = r_field + 3'd1;
                    end
                end
                PH_SIZE: begin
                    n_bytes = {r_bytes[7:0], i_byte};
                    if (r_field == 3'd1) begin
                        n_field = 3'd0;
                        if (n_bytes == 16'd0) begin
                            n_phase = PH_RCOUNT;
                        end else begin
                            n_waddr = r_offset;
                            if (grow_end > r_size) begin
                                n_size = grow_end;
                            end
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_field = r_field + 3'd1;
                    end
                end
                PH_DATA: begin
                    o_res_valid   = 1'b1;
                    o_res.kind    = KIND_WRITE;
                    o_res.address = r_waddr;
                    o_res.value   = i_byte;
                    n_waddr       = r_waddr + 24'd1;
                    n_bytes       = r_bytes - 16'd1;
                    if (n_bytes == 16'd0) begin
                        n_records = rec_inc;
                        n_phase   = PH_OFFSET;
                    end
                end
                PH_RCOUNT: begin
                    n_bytes = {r_bytes[7:0], i_byte};
                    if (r_field == 3'd1) begin
                        n_field = 3'd0;
                        n_phase = PH_RVALUE;
                    end else begin
                        n_field = r_field + 3'd1;
                    end
                end
                PH_RVALUE: begin
                    if (grow_end > r_size) begin
                        n_size = grow_end;
                    end
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_FILL;
                    o_res.address    = r_offset;
                    o_res.value      = i_byte;
                    o_res.run_length = r_bytes;
                    n_records        = rec_inc;
                    n_phase          = PH_OFFSET;
                end
                default: begin
                    n_finished   = 1'b1;
                    o_res_valid  = 1'b1;
                    o_res.status = ST_STREAM_END;
                end
            endcase

            // end of source ends the parse unless already ended
            if (i_last && !n_finished) begin
                n_finished   = 1'b1;
                o_res_valid  = 1'b1;
                o_res.status = (n_phase == PH_HEAD) ? ST_BAD_HDR : ST_STREAM_END;
            end
        end

        o_res.image_size   = (n_phase == PH_HEAD) ? {1'b0, i_orig_size} : n_size;
        o_res.record_count = n_records;
    end

    // state registers advance on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEAD;
            r_field    <= 3'd0;
            r_marker   <= 24'd0;
            r_offset   <= 24'd0;
            r_bytes    <= 16'd0;
            r_waddr    <= 24'd0;
            r_size     <= 25'd0;
            r_records  <= 16'd0;
            r_finished <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_field    <= n_field;
            r_marker   <= n_marker;
            r_offset   <= n_offset;
            r_bytes    <= n_bytes;
            r_waddr    <= n_waddr;
            r_size     <= n_size;
            r_records  <= n_records;
            r_finished <= n_finished;
        end
    end

endmodule

/* rtl/ips_patch_stream_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_patch_stream_parser_unit
// IPS patch parser: one patch byte per transfer in, write and fill commands
// plus end-of-parse status out, through a registered output stage.
// ----------------------------------------------------------------------------
// A result is registered and appears on the master side in the cycle after its byte.
// Throughput: one byte per cycle unless the master side stalls; the parse state
//   machine settles in the cycle of the transfer and the output register takes the result.
// Input is taken whenever the output register is empty or being drained.
// Reset (synchronous, active low) returns to the header check, clears all
//   counters and the original_size register, and empties the output.
// ----------------------------------------------------------------------------
module ips_patch_stream_parser_unit
    import ipsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: original_size
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    // patch byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] patch_byte
    input  logic        s_axis_tlast,   // stream_end
    // command stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [23:0] address, [31:24] value, [47:32] run_length, [72:48] image_size,
    // [74:73] status, [90:75] record_count, [95:91] zero
    output logic [95:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser   // [1:0] kind
);

    logic [23:0] r_orig_size;
    logic        r_out_valid;
    t_result     r_out;
    logic        in_xfer;
    logic        res_valid;
    t_result     res;

    // original image size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orig_size <= 24'd0;
        end else if (i_cfg_wr_en) begin
            r_orig_size <= i_cfg_wr_data;
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    ipsp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_orig_size (r_orig_size),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {5'd0, r_out.record_count, r_out.status, r_out.image_size,
                            r_out.run_length, r_out.value, r_out.address};

    // a single-byte write always carries a length of one
    a_write_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_WRITE |-> r_out.run_length == 16'd1)
        else $error("write command with run length other than one");

    // a status-only result always reports why the parse ended
    a_done_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_DONE |-> r_out.status != ST_BUSY)
        else $error("status-only result without end status");

    // nothing follows a result that ended the parse
    a_no_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && m_axis_tready && r_out.status != ST_BUSY |=> !r_out_valid)
        else $error("result produced after the parse ended");

endmodule
